// File: rtl/eight_bit_alu_status_flags_defines.svh
// Assertion macros shared by the ALU and status flag block.
`ifndef EIGHT_BIT_ALU_STATUS_FLAGS_DEFINES_SVH
`define EIGHT_BIT_ALU_STATUS_FLAGS_DEFINES_SVH

// Checks a property on every clock edge, including those in reset.
`define EBALU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

// Checks a property only while the block is out of reset.
`define EBALU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`endif

// File: rtl/ebalu_pkg.sv
// Types and constants of the 8-bit ALU and status flag block.
`default_nettype none

package ebalu_pkg;

    typedef enum logic [4:0] {
        OP_ADC    = 5'd0,
        OP_SBC    = 5'd1,
        OP_AND    = 5'd2,
        OP_ORA    = 5'd3,
        OP_EOR    = 5'd4,
        OP_CMP    = 5'd5,
        OP_BIT    = 5'd6,
        OP_ASL    = 5'd7,
        OP_LSR    = 5'd8,
        OP_ROL    = 5'd9,
        OP_ROR    = 5'd10,
        OP_INC    = 5'd11,
        OP_DEC    = 5'd12,
        OP_LOAD   = 5'd13,
        OP_CLC    = 5'd14,
        OP_SEC    = 5'd15,
        OP_CLI    = 5'd16,
        OP_SEI    = 5'd17,
        OP_CLD    = 5'd18,
        OP_SED    = 5'd19,
        OP_CLV    = 5'd20,
        OP_BRANCH = 5'd21,
        OP_PULL   = 5'd22,
        OP_PUSH   = 5'd23
    } alu_op_t;

    typedef enum logic [1:0] {
        COND_N = 2'd0,
        COND_V = 2'd1,
        COND_C = 2'd2,
        COND_Z = 2'd3
    } cond_flag_t;

    localparam int unsigned ST_C = 0;
    localparam int unsigned ST_Z = 1;
    localparam int unsigned ST_I = 2;
    localparam int unsigned ST_D = 3;
    localparam int unsigned ST_B = 4;
    localparam int unsigned ST_U = 5;
    localparam int unsigned ST_V = 6;
    localparam int unsigned ST_N = 7;

    localparam logic [7:0] PUSH_MASK = 8'h30;

    typedef struct packed {
        logic [4:0] operation;
        logic [7:0] reg_value;
        logic [7:0] operand;
        logic [7:0] status_in;
        logic [2:0] branch_cond;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] result;
        logic [7:0] status_out;
        logic       branch_taken;
    } out_beat_t;

endpackage

`default_nettype wire

// File: rtl/ebalu_core.sv
// Combinational ALU datapath and status flag update for one beat.
`default_nettype none

module ebalu_core
    import ebalu_pkg::*;
(
    input  in_beat_t  in_beat,
    output out_beat_t out_beat
);

    alu_op_t    op;
    logic [7:0] r;
    logic [7:0] m;
    logic [7:0] b;
    logic       cin;
    logic [8:0] sum;
    logic [8:0] diff;
    logic [7:0] res;
    logic [7:0] st;
    logic       taken;
    logic       flag_sel;

    assign op   = alu_op_t'(in_beat.operation);
    assign r    = in_beat.reg_value;
    assign m    = in_beat.operand;
    assign cin  = in_beat.status_in[ST_C];
    assign b    = (op == OP_SBC) ? ~m : m;
    assign sum  = {1'b0, r} + {1'b0, b} + {8'd0, cin};
    assign diff = {1'b0, r} - {1'b0, m};

    always_comb begin
        case (cond_flag_t'(in_beat.branch_cond[2:1]))
            COND_N:  flag_sel = in_beat.status_in[ST_N];
            COND_V:  flag_sel = in_beat.status_in[ST_V];
            COND_C:  flag_sel = in_beat.status_in[ST_C];
            COND_Z:  flag_sel = in_beat.status_in[ST_Z];
            default: flag_sel = in_beat.status_in[ST_Z];
        endcase
    end

    always_comb begin
        res   = r;
        st    = in_beat.status_in;
        taken = 1'b0;
        case (op)
            OP_ADC, OP_SBC: begin
                res      = sum[7:0];
                st[ST_Z] = (sum[7:0] == 8'd0);
                st[ST_N] = sum[7];
                st[ST_C] = sum[8];
                st[ST_V] = ~(r[7] ^ b[7]) & (r[7] ^ sum[7]);
            end
            OP_AND, OP_ORA, OP_EOR, OP_ASL, OP_LSR, OP_ROL, OP_ROR,
            OP_INC, OP_DEC, OP_LOAD: begin
                case (op)
                    OP_AND:  res = r & m;
                    OP_ORA:  res = r | m;
                    OP_EOR:  res = r ^ m;
                    OP_ASL:  res = {m[6:0], 1'b0};
                    OP_LSR:  res = {1'b0, m[7:1]};
                    OP_ROL:  res = {m[6:0], cin};
                    OP_ROR:  res = {cin, m[7:1]};
                    OP_INC:  res = m + 8'd1;
                    OP_DEC:  res = m - 8'd1;
                    default: res = m;
                endcase
                st[ST_Z] = (res == 8'd0);
                st[ST_N] = res[7];
                if (op == OP_ASL || op == OP_ROL) begin
                    st[ST_C] = m[7];
                end else if (op == OP_LSR || op == OP_ROR) begin
                    st[ST_C] = m[0];
                end
            end
            OP_CMP: begin
                st[ST_Z] = (diff[7:0] == 8'd0);
                st[ST_N] = diff[7];
                st[ST_C] = ~diff[8];
            end
            OP_BIT: begin
                st[ST_Z] = ((r & m) == 8'd0);
                st[ST_N] = m[7];
                st[ST_V] = m[6];
            end
            OP_CLC:    st[ST_C] = 1'b0;
            OP_SEC:    st[ST_C] = 1'b1;
            OP_CLI:    st[ST_I] = 1'b0;
            OP_SEI:    st[ST_I] = 1'b1;
            OP_CLD:    st[ST_D] = 1'b0;
            OP_SED:    st[ST_D] = 1'b1;
            OP_CLV:    st[ST_V] = 1'b0;
            OP_BRANCH: taken = (flag_sel == in_beat.branch_cond[0]);
            OP_PULL: begin
                st       = m;
                st[ST_B] = 1'b0;
                st[ST_U] = 1'b0;
            end
            OP_PUSH:   res = in_beat.status_in | PUSH_MASK;
            default: begin
                res   = r;
                st    = in_beat.status_in;
                taken = 1'b0;
            end
        endcase
    end

    assign out_beat.result       = res;
    assign out_beat.status_out   = st;
    assign out_beat.branch_taken = taken;

endmodule

`default_nettype wire

// File: rtl/eight_bit_alu_status_flags.sv
// Top level of the 6502-style 8-bit ALU and status flag unit.
//
// The input channel (s_valid, s_ready, s_beat) carries one operation per beat:
// the operation code, a register value, an operand byte, the status byte and
// a branch condition. The result channel (m_valid, m_ready, m_beat) returns
// one beat per input beat holding the data byte, the new status byte and the
// branch-taken bit, in the same order as the inputs arrived.
// Every beat is registered on entry, goes through one pass of ALU and flag
// logic, and lands in the output register, which drives m_valid and m_beat.
// One beat can be accepted in every cycle while m_ready stays high.
// A synchronous low aresetn empties both stages and drops m_valid.
// When the receiver holds m_ready low, the output register keeps its beat and
// the input stage still takes one more beat; after that s_ready falls until
// the output drains.
`default_nettype none

`include "eight_bit_alu_status_flags_defines.svh"

module eight_bit_alu_status_flags
    import ebalu_pkg::*;
(
    input  wire       aclk,
    input  wire       aresetn,
    input  wire       s_valid,
    output logic      s_ready,
    input  in_beat_t  s_beat,
    output logic      m_valid,
    input  wire       m_ready,
    output out_beat_t m_beat
);

    logic      in_vld_reg;
    logic      in_vld_next;
    in_beat_t  in_beat_reg;
    logic      out_vld_reg;
    logic      out_vld_next;
    out_beat_t out_beat_reg;
    out_beat_t alu_beat;
    logic      out_load;
    logic      in_load;

    assign out_load     = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready      = !in_vld_reg || out_load;
    assign in_load      = s_valid && s_ready;
    assign in_vld_next  = in_load ? 1'b1 : (out_load ? 1'b0 : in_vld_reg);
    assign out_vld_next = out_load ? 1'b1 : (m_ready ? 1'b0 : out_vld_reg);

    ebalu_core u_core (
        .in_beat  (in_beat_reg),
        .out_beat (alu_beat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_beat_reg <= s_beat;
        end
        if (out_load) begin
            out_beat_reg <= alu_beat;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_beat  = out_beat_reg;

    `EBALU_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_valid && !in_vld_reg,
        "Reset left a beat in the pipe.")
    `EBALU_ASSERT(a_accept_fills, s_valid && s_ready |=> in_vld_reg,
        "Accepted beat did not enter the input stage.")
    `EBALU_ASSERT(a_advance, in_vld_reg && !out_vld_reg |=> out_vld_reg,
        "Input stage did not move into the empty output stage.")
    `EBALU_ASSERT(a_stall_blocks, out_vld_reg && !m_ready && in_vld_reg |-> !s_ready,
        "Input taken while both stages were full and stalled.")

endmodule

`default_nettype wire

// File: tb/eight_bit_alu_status_flags_tb.sv
// Self-checking testbench for the 8-bit ALU and status flag unit, with random stalls on both sides.
`default_nettype none

module eight_bit_alu_status_flags_tb;
    import ebalu_pkg::*;

    localparam int unsigned  HALF_PERIOD  = 10;
    localparam int unsigned  RESET_CYCLES = 7;
    localparam int unsigned  STALL_LIMIT  = 2000;
    localparam int unsigned  HOLD_CYCLES  = 100;
    localparam int unsigned  SETTLE_TICKS = 4;
    localparam int unsigned  PRINT_CAP    = 20;
    localparam logic [4:0]   OP_SPARE_LO  = 5'd24;
    localparam logic [4:0]   OP_SPARE_HI  = 5'd31;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_beat_t   s_beat  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_beat_t  m_beat;

    out_beat_t  expected_results[$];
    int unsigned error_count   = 0;
    int unsigned beats_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned idle_cycles   = 0;
    bit          sender_idles   = 1'b1;
    bit          receiver_idles = 1'b1;
    bit          hold_request   = 1'b0;

    eight_bit_alu_status_flags u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_beat  (s_beat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_beat  (m_beat)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    function automatic logic [7:0] with_zero_neg(logic [7:0] st, logic [7:0] v);
        logic [7:0] s;
        s = st;
        s[ST_Z] = (v == 8'h00);
        s[ST_N] = v[7];
        return s;
    endfunction

    function automatic out_beat_t predict_alu(in_beat_t b);
        logic [7:0] r;
        logic [7:0] m;
        logic [7:0] st;
        logic [7:0] res;
        logic [7:0] addend;
        logic [8:0] sum;
        logic       cin;
        logic       taken;
        logic       flag;
        out_beat_t  o;
        r      = b.reg_value;
        m      = b.operand;
        st     = b.status_in;
        res    = r;
        taken  = 1'b0;
        cin    = st[ST_C];
        case (alu_op_t'(b.operation))
            OP_ADC, OP_SBC: begin
                addend = (alu_op_t'(b.operation) == OP_SBC) ? ~m : m;
                sum    = {1'b0, r} + {1'b0, addend} + {8'h00, cin};
                res    = sum[7:0];
                st     = with_zero_neg(st, res);
                st[ST_C] = sum[8];
                st[ST_V] = ~(r[7] ^ addend[7]) & (r[7] ^ res[7]);
            end
            OP_AND: begin
                res = r & m;
                st  = with_zero_neg(st, res);
            end
            OP_ORA: begin
                res = r | m;
                st  = with_zero_neg(st, res);
            end
            OP_EOR: begin
                res = r ^ m;
                st  = with_zero_neg(st, res);
            end
            OP_CMP: begin
                st = with_zero_neg(st, r - m);
                st[ST_C] = (r >= m);
            end
            OP_BIT: begin
                st[ST_Z] = ((r & m) == 8'h00);
                st[ST_N] = m[7];
                st[ST_V] = m[6];
            end
            OP_ASL: begin
                res = {m[6:0], 1'b0};
                st  = with_zero_neg(st, res);
                st[ST_C] = m[7];
            end
            OP_LSR: begin
                res = {1'b0, m[7:1]};
                st  = with_zero_neg(st, res);
                st[ST_C] = m[0];
            end
            OP_ROL: begin
                res = {m[6:0], cin};
                st  = with_zero_neg(st, res);
                st[ST_C] = m[7];
            end
            OP_ROR: begin
                res = {cin, m[7:1]};
                st  = with_zero_neg(st, res);
                st[ST_C] = m[0];
            end
            OP_INC: begin
                res = m + 8'h01;
                st  = with_zero_neg(st, res);
            end
            OP_DEC: begin
                res = m - 8'h01;
                st  = with_zero_neg(st, res);
            end
            OP_LOAD: begin
                res = m;
                st  = with_zero_neg(st, res);
            end
            OP_CLC: st[ST_C] = 1'b0;
            OP_SEC: st[ST_C] = 1'b1;
            OP_CLI: st[ST_I] = 1'b0;
            OP_SEI: st[ST_I] = 1'b1;
            OP_CLD: st[ST_D] = 1'b0;
            OP_SED: st[ST_D] = 1'b1;
            OP_CLV: st[ST_V] = 1'b0;
            OP_BRANCH: begin
                case (cond_flag_t'(b.branch_cond[2:1]))
                    COND_N:  flag = st[ST_N];
                    COND_V:  flag = st[ST_V];
                    COND_C:  flag = st[ST_C];
                    default: flag = st[ST_Z];
                endcase
                taken = (flag == b.branch_cond[0]);
            end
            OP_PULL: begin
                st = m;
                st[ST_B] = 1'b0;
                st[ST_U] = 1'b0;
            end
            OP_PUSH: res = st | PUSH_MASK;
            default: ;
        endcase
        o.result       = res;
        o.status_out   = st;
        o.branch_taken = taken;
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (error_count < PRINT_CAP) begin
            $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
        error_count++;
    endtask

    // Accepted beats feed the predictor; delivered beats are checked in order.
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_alu(s_beat));
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result beat", int'(m_beat), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_beat.result !== want.result)
                        report_mismatch("result", int'(m_beat.result), int'(want.result));
                    if (m_beat.status_out !== want.status_out)
                        report_mismatch("status_out", int'(m_beat.status_out),
                                        int'(want.status_out));
                    if (m_beat.branch_taken !== want.branch_taken)
                        report_mismatch("branch_taken", int'(m_beat.branch_taken),
                                        int'(want.branch_taken));
                end
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end else if (stall_left == 0 && receiver_idles && $urandom_range(3, 0) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("eight_bit_alu_status_flags_tb: errors");
        $finish;
    end

    function automatic in_beat_t make_beat(logic [4:0] op, logic [7:0] r, logic [7:0] m,
                                           logic [7:0] st, logic [2:0] cond);
        in_beat_t b;
        b.operation   = op;
        b.reg_value   = r;
        b.operand     = m;
        b.status_in   = st;
        b.branch_cond = cond;
        return b;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(11, 0))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'h7f;
            3:       return 8'h80;
            default: return 8'($urandom_range(255, 0));
        endcase
    endfunction

    function automatic in_beat_t random_beat();
        logic [4:0] op;
        if ($urandom_range(15, 0) == 0)
            op = 5'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        else
            op = 5'($urandom_range(OP_PUSH, OP_ADC));
        return make_beat(op, pick_byte(), pick_byte(), 8'($urandom_range(255, 0)),
                         3'($urandom_range(7, 0)));
    endfunction

    // Called at a clock edge; returns at a clock edge.
    task automatic send_beat(in_beat_t b);
        int unsigned gap;
        s_beat  <= b;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
        beats_sent++;
        gap = sender_idles ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic test_directed_corners();
        send_beat(make_beat(OP_ADC, 8'h7f, 8'h01, 8'h00, 3'd0));
        send_beat(make_beat(OP_ADC, 8'hff, 8'h00, 8'h01, 3'd0));
        send_beat(make_beat(OP_SBC, 8'h80, 8'h01, 8'h01, 3'd0));
        send_beat(make_beat(OP_SBC, 8'h00, 8'h00, 8'h00, 3'd0));
        send_beat(make_beat(OP_AND, 8'hff, 8'h00, 8'hff, 3'd0));
        send_beat(make_beat(OP_ORA, 8'h80, 8'h01, 8'h00, 3'd0));
        send_beat(make_beat(OP_EOR, 8'hff, 8'hff, 8'h80, 3'd0));
        send_beat(make_beat(OP_CMP, 8'h40, 8'h40, 8'h00, 3'd0));
        send_beat(make_beat(OP_CMP, 8'h00, 8'hff, 8'hff, 3'd0));
        send_beat(make_beat(OP_BIT, 8'h00, 8'hc0, 8'h00, 3'd0));
        send_beat(make_beat(OP_ASL, 8'h00, 8'h80, 8'h00, 3'd0));
        send_beat(make_beat(OP_LSR, 8'h00, 8'h01, 8'h00, 3'd0));
        send_beat(make_beat(OP_ROL, 8'h00, 8'h80, 8'h01, 3'd0));
        send_beat(make_beat(OP_ROR, 8'h00, 8'h01, 8'h01, 3'd0));
        send_beat(make_beat(OP_INC, 8'h00, 8'hff, 8'h00, 3'd0));
        send_beat(make_beat(OP_DEC, 8'h00, 8'h00, 8'h00, 3'd0));
        send_beat(make_beat(OP_LOAD, 8'hff, 8'h00, 8'h80, 3'd0));
        send_beat(make_beat(OP_CLC, 8'h12, 8'h34, 8'hff, 3'd0));
        send_beat(make_beat(OP_SEC, 8'h12, 8'h34, 8'h00, 3'd0));
        send_beat(make_beat(OP_CLI, 8'h12, 8'h34, 8'hff, 3'd0));
        send_beat(make_beat(OP_SEI, 8'h12, 8'h34, 8'h00, 3'd0));
        send_beat(make_beat(OP_CLD, 8'h12, 8'h34, 8'hff, 3'd0));
        send_beat(make_beat(OP_SED, 8'h12, 8'h34, 8'h00, 3'd0));
        send_beat(make_beat(OP_CLV, 8'h12, 8'h34, 8'hff, 3'd0));
        send_beat(make_beat(OP_BRANCH, 8'h55, 8'haa, 8'h02, 3'd7));
        send_beat(make_beat(OP_BRANCH, 8'h55, 8'haa, 8'h00, 3'd0));
        send_beat(make_beat(OP_PULL, 8'h55, 8'hff, 8'h00, 3'd0));
        send_beat(make_beat(OP_PUSH, 8'h55, 8'haa, 8'h00, 3'd0));
        send_beat(make_beat(OP_SPARE_HI, 8'ha5, 8'h5a, 8'hc3, 3'd5));
        drain_results();
    endtask

    task automatic test_branch_conditions();
        in_beat_t b;
        repeat (64) begin
            b = make_beat(OP_BRANCH, pick_byte(), pick_byte(), 8'($urandom_range(255, 0)),
                          3'($urandom_range(7, 0)));
            send_beat(b);
        end
        drain_results();
    endtask

    task automatic test_output_backpressure();
        sender_idles = 1'b0;
        hold_request = 1'b1;
        repeat (30) send_beat(random_beat());
        drain_results();
        sender_idles = 1'b1;
    endtask

    task automatic test_random_mix();
        for (int chunk = 0; chunk < 8; chunk++) begin
            sender_idles   = (chunk % 4) != 1;
            receiver_idles = (chunk % 4) != 2 && (chunk % 4) != 1;
            repeat (92) send_beat(random_beat());
        end
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        drain_results();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_corners();
        test_branch_conditions();
        test_output_backpressure();
        test_random_mix();
        if (expected_results.size() != 0)
            report_mismatch("results never delivered", expected_results.size(), 0);
        $display("Sent %0d beats and checked %0d results: every operation code, all branch",
                 beats_sent, results_seen);
        $display("conditions, random stalls on both channels and one long output hold-off.");
        if (error_count == 0) begin
            $display("eight_bit_alu_status_flags_tb: clean");
        end else begin
            $display("eight_bit_alu_status_flags_tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
